[design/dfnc_pkg.sv]
// dfnc_pkg: permutation tables, queue entry type and bit-level helpers
// for the sbox-less des-style feistel cipher; no dependencies
`default_nettype none

package dfnc_pkg;

    localparam int ROUNDS_DEF = 16;
    localparam int ROUNDS_MAX = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        op;
        logic [31:0] l;
        logic [31:0] r;
    } t_qentry;

    typedef struct packed {
        logic    push;
        t_qentry data;
    } t_push;

    localparam logic [6:0] IP_TAB [0:63] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] PC1_TAB [0:55] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [6:0] PC2_TAB [0:47] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28,
        7'd15, 7'd6,  7'd21, 7'd10, 7'd23, 7'd19, 7'd12, 7'd4,
        7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
        7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40,
        7'd51, 7'd45, 7'd33, 7'd48, 7'd44, 7'd49, 7'd39, 7'd56,
        7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
    };

    localparam logic [6:0] EXP_TAB [0:47] = '{
        7'd32, 7'd1,  7'd2,  7'd3,  7'd4,  7'd5,
        7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,
        7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13,
        7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17,
        7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21,
        7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
        7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
        7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd1
    };

    localparam logic [6:0] SEL_TAB [0:31] = '{
        7'd35, 7'd38, 7'd46, 7'd6,  7'd43, 7'd40, 7'd14, 7'd45,
        7'd33, 7'd19, 7'd26, 7'd15, 7'd23, 7'd8,  7'd22, 7'd10,
        7'd12, 7'd11, 7'd5,  7'd25, 7'd27, 7'd21, 7'd16, 7'd31,
        7'd28, 7'd32, 7'd34, 7'd24, 7'd9,  7'd37, 7'd2,  7'd1
    };

    localparam logic [6:0] PERM_TAB [0:31] = '{
        7'd16, 7'd7,  7'd20, 7'd21, 7'd29, 7'd12, 7'd28, 7'd17,
        7'd1,  7'd15, 7'd23, 7'd26, 7'd5,  7'd18, 7'd31, 7'd10,
        7'd2,  7'd8,  7'd24, 7'd14, 7'd32, 7'd27, 7'd3,  7'd9,
        7'd19, 7'd13, 7'd30, 7'd6,  7'd22, 7'd11, 7'd4,  7'd25
    };

    localparam logic [6:0] FP_TAB [0:63] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    // cumulative left rotation of c and d after each round, modulo 28
    localparam logic [4:0] CUM_SHIFT [0:15] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd0
    };

    function automatic logic [63:0] perm_ip(input logic [63:0] s);
        logic [63:0] o;
        for (int i = 0; i < 64; i++) begin
            o[63-i] = s[6'(64 - int'(IP_TAB[i]))];
        end
        return o;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] s);
        logic [63:0] o;
        for (int i = 0; i < 64; i++) begin
            o[63-i] = s[6'(64 - int'(FP_TAB[i]))];
        end
        return o;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] s);
        logic [55:0] o;
        for (int i = 0; i < 56; i++) begin
            o[55-i] = s[6'(64 - int'(PC1_TAB[i]))];
        end
        return o;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] s);
        logic [47:0] o;
        for (int i = 0; i < 48; i++) begin
            o[47-i] = s[6'(56 - int'(PC2_TAB[i]))];
        end
        return o;
    endfunction

    function automatic logic [27:0] rotl28(input logic [27:0] x, input logic [4:0] s);
        logic [55:0] dbl;
        dbl = {x, x} << s;
        return dbl[55:28];
    endfunction

    // subkey for round k, pure wiring of the key for a constant k
    function automatic logic [47:0] subkey(input logic [63:0] key, input logic [3:0] k);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        cd = perm_pc1(key);
        c  = rotl28(cd[55:28], CUM_SHIFT[k]);
        d  = rotl28(cd[27:0], CUM_SHIFT[k]);
        return perm_pc2({c, d});
    endfunction

    function automatic logic [31:0] round_fn(input logic [31:0] half, input logic [47:0] sk);
        logic [47:0] e;
        logic [31:0] s;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) begin
            e[47-i] = half[5'(32 - int'(EXP_TAB[i]))];
        end
        e = e ^ sk;
        for (int i = 0; i < 32; i++) begin
            s[31-i] = e[6'(48 - int'(SEL_TAB[i]))];
        end
        for (int i = 0; i < 32; i++) begin
            p[31-i] = s[5'(32 - int'(PERM_TAB[i]))];
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[design/dfnc_front.sv]
// dfnc_front: takes a block on start, applies the initial permutation
// and hands the split halves with the operation to the queue; uses dfnc_pkg
`default_nettype none

module dfnc_front (
    input  wire logic           i_start,
    input  wire logic           i_full,
    input  wire logic           i_operation,
    input  wire logic [63:0]    i_block_in,
    output dfnc_pkg::t_push     o_push,
    output logic                o_busy
);

    logic [63:0] w_ip;

    always_comb begin
        w_ip             = dfnc_pkg::perm_ip(i_block_in);
        o_busy           = i_full;
        o_push.push      = i_start && !i_full;
        o_push.data.op   = i_operation;
        o_push.data.l    = w_ip[63:32];
        o_push.data.r    = w_ip[31:0];
    end

endmodule

`default_nettype wire

[design/dfnc_queue.sv]
// dfnc_queue: short flip-flop queue between the front and the round pipeline
// uses dfnc_pkg for the entry type
`default_nettype none

module dfnc_queue #(
    parameter int DEPTH = dfnc_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dfnc_pkg::t_push    i_push,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output dfnc_pkg::t_qentry       o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dfnc_pkg::t_qentry r_mem [DEPTH];
    logic [PW-1:0]     r_wptr, n_wptr;
    logic [PW-1:0]     r_rptr, n_rptr;
    logic [CW-1:0]     r_cnt,  n_cnt;
    logic              w_do_pop;

    always_comb begin
        o_full   = (r_cnt == CW'(DEPTH));
        o_empty  = (r_cnt == '0);
        o_head   = r_mem[r_rptr];
        w_do_pop = i_pop && !o_empty;
        n_wptr   = r_wptr;
        n_rptr   = r_rptr;
        if (i_push.push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        n_cnt = r_cnt + CW'(i_push.push) - CW'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wptr] <= i_push.data;
        end
    end

endmodule

`default_nettype wire

[design/dfnc_rounds.sv]
// dfnc_rounds: one register stage per feistel round, final permutation
// into the output register; uses dfnc_pkg tables and key schedule
`default_nettype none

module dfnc_rounds #(
    parameter int ROUNDS = dfnc_pkg::ROUNDS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [63:0]        i_key,
    input  wire logic               i_empty,
    input  wire dfnc_pkg::t_qentry  i_head,
    output logic                    o_pop,
    output logic                    o_valid,
    output logic [63:0]             o_block_out
);

    // round count capped at the length of the key schedule
    localparam int NR = (ROUNDS > dfnc_pkg::ROUNDS_MAX) ? dfnc_pkg::ROUNDS_MAX : ROUNDS;

    logic [47:0]       w_sub [NR];
    logic              r_vld [NR+1];
    dfnc_pkg::t_qentry r_stg [NR+1];
    logic              r_valid;
    logic [63:0]       r_block_out;

    assign o_pop       = !i_empty;
    assign o_valid     = r_valid;
    assign o_block_out = r_block_out;

    for (genvar k = 0; k < NR; k++) begin : g_key
        assign w_sub[k] = dfnc_pkg::subkey(i_key, 4'(k));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg[0] <= i_head;
    end

    for (genvar k = 0; k < NR; k++) begin : g_round
        logic [47:0]       w_sk;
        dfnc_pkg::t_qentry w_nxt;

        always_comb begin
            w_sk     = r_stg[k].op ? w_sub[NR-1-k] : w_sub[k];
            w_nxt.op = r_stg[k].op;
            w_nxt.l  = r_stg[k].r;
            w_nxt.r  = r_stg[k].l ^ dfnc_pkg::round_fn(r_stg[k].r, w_sk);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_stg[k+1] <= w_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vld[NR];
        end
    end

    // halves swapped before the final permutation
    always_ff @(posedge i_clk) begin
        r_block_out <= dfnc_pkg::perm_fp({r_stg[NR].r, r_stg[NR].l});
    end

endmodule

`default_nettype wire

[design/des_feistel_no_sbox_cipher.sv]
// des_feistel_no_sbox_cipher: top level with key register and apb port,
// front, queue and round pipeline; uses dfnc_pkg, dfnc_front, dfnc_queue, dfnc_rounds
//
// Encrypts (operation 0) or decrypts (operation 1) one 64-bit block per start
// pulse with a DES-style Feistel network of ROUNDS rounds (at most 16) whose S-boxes
// are replaced by a fixed bit selection. A block is taken at every clock edge where
// start is high and busy is low; busy stays low in normal use, so one block per cycle
// is sustained. Each result appears on o_block_out for exactly one cycle with
// o_valid high, after its transfer has passed the queue slot, the queue head
// register, one register stage per round and the output register; results leave in
// the order the blocks came in and cannot be stalled. The 64-bit key lives at
// apb byte address 0 and must only be written while no block is in flight.
`default_nettype none

module des_feistel_no_sbox_cipher #(
    parameter int ROUNDS = dfnc_pkg::ROUNDS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire logic           i_operation,
    input  wire logic [63:0]    i_block_in,
    output logic                o_valid,
    output logic [63:0]         o_block_out,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [63:0]    pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int LIVE_ROUNDS =
        (ROUNDS > dfnc_pkg::ROUNDS_MAX) ? dfnc_pkg::ROUNDS_MAX : ROUNDS;

    logic [63:0]        r_cipher_key;
    logic               w_wr;
    logic               w_full;
    logic               w_empty;
    logic               w_pop;
    dfnc_pkg::t_push    w_push;
    dfnc_pkg::t_qentry  w_head;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[3] == 1'b0);
    assign prdata = (paddr[3] == 1'b0) ? r_cipher_key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (w_wr) begin
            r_cipher_key <= pwdata;
        end
    end

    dfnc_front u_front (
        .i_start     (start),
        .i_full      (w_full),
        .i_operation (i_operation),
        .i_block_in  (i_block_in),
        .o_push      (w_push),
        .o_busy      (busy)
    );

    dfnc_queue #(
        .DEPTH (dfnc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    dfnc_rounds #(
        .ROUNDS (ROUNDS)
    ) u_rounds (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (r_cipher_key),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_block_out (o_block_out)
    );

    // every transfer yields exactly one result
    a_latency_fwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(LIVE_ROUNDS+3) o_valid)
        else $error("accepted block produced no result");

    a_latency_back : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, LIVE_ROUNDS+3))
        else $error("result without matching transfer");

    // the round pipeline drains the queue every cycle, so it never fills
    a_never_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |=> !w_full)
        else $error("queue filled up");

endmodule

`default_nettype wire
